### hw/rtl/ssl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types, codes and arithmetic for the servo slew limiter.
// ----------------------------------------------------------------------------
package ssl_pkg;

    localparam int NUM_AXES     = 3;
    localparam int ANGLE_W      = 8;
    localparam int PERIOD_W     = 10;
    localparam int COMPARE_W    = 12;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 10;

    typedef logic [ANGLE_W-1:0]   t_angle;
    typedef logic [PERIOD_W-1:0]  t_period;
    typedef logic [COMPARE_W-1:0] t_compare;
    typedef logic [1:0]           t_axis_sel;
    typedef logic [1:0]           t_status;

    // Input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    // Axis selection codes
    localparam t_axis_sel AXIS_BASE  = 2'd0;
    localparam t_axis_sel AXIS_FRONT = 2'd1;
    localparam t_axis_sel AXIS_REAR  = 2'd2;

    // Result status codes
    localparam t_status STATUS_TICK   = 2'd0;
    localparam t_status STATUS_ACCEPT = 2'd1;
    localparam t_status STATUS_REJECT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_PERIOD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_MIN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_MAX    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FRONT_MIN   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FRONT_MAX   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_REAR_MIN    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_REAR_MAX    = 3'd6;

    // Reset values
    localparam t_period RST_STEP_PERIOD = 10'd50;
    localparam t_angle  RST_BASE_MIN    = 8'd30;
    localparam t_angle  RST_BASE_MAX    = 8'd170;
    localparam t_angle  RST_FRONT_MIN   = 8'd14;
    localparam t_angle  RST_FRONT_MAX   = 8'd128;
    localparam t_angle  RST_REAR_MIN    = 8'd52;
    localparam t_angle  RST_REAR_MAX    = 8'd150;
    localparam t_angle  RST_BASE_ANGLE  = 8'd145;
    localparam t_angle  RST_FRONT_ANGLE = 8'd90;
    localparam t_angle  RST_REAR_ANGLE  = 8'd90;

    localparam t_angle  ANGLE_FULL = 8'd180;
    localparam int      PULSE_BASE = 500;

    // Reciprocal of 9 scaled by 2^18, rounded up; exact for products below 2^15
    localparam int RECIP_SHIFT = 18;
    localparam logic [14:0] RECIP_NINE = 15'((1 << RECIP_SHIFT) / 9 + 1);

    // Per-axis control for one processed item
    typedef struct packed {
        logic   step;
        logic   goal_we;
        t_angle goal;
    } t_axis_ctrl;

    // PWM compare value floor(angle*100/9)+500
    function automatic t_compare angle_to_compare(input t_angle angle);
        logic [14:0] scaled;
        logic [29:0] prod;
        logic [11:0] quot;
        scaled = 15'(angle) * 15'd100;
        prod   = 30'(scaled) * 30'(RECIP_NINE);
        quot   = prod[RECIP_SHIFT +: 12];
        return quot + t_compare'(PULSE_BASE);
    endfunction

endpackage
`default_nettype wire

### hw/rtl/servo_slew_limiter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// servo_slew_limiter_top
// Three-axis servo position ramp with per-axis target limits.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, then the result register;
// state is updated on the same edge as the result.
// Throughput: one item per cycle while the consumer takes results; the input
// register can hold one new item while a result waits for the consumer.
// Reset: synchronous active low; angles 145/90/90, counter and fault cleared,
// configuration registers return to their defaults. Config port always ready.
// ----------------------------------------------------------------------------
module servo_slew_limiter_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // input items
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic                                 i_cmd,
    input  wire ssl_pkg::t_axis_sel                   i_axis,
    input  wire ssl_pkg::t_angle                      i_target_angle,
    // result items
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output ssl_pkg::t_status                          o_status,
    output ssl_pkg::t_angle                           o_base_angle,
    output ssl_pkg::t_angle                           o_front_angle,
    output ssl_pkg::t_angle                           o_rear_angle,
    output ssl_pkg::t_compare                         o_base_compare,
    output ssl_pkg::t_compare                         o_front_compare,
    output ssl_pkg::t_compare                         o_rear_compare,
    output logic [ssl_pkg::NUM_AXES-1:0]              o_moving_mask,
    output logic                                      o_front_fault,
    // configuration writes
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [ssl_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  wire logic [ssl_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import ssl_pkg::*;

    // Configuration registers
    t_period r_step_period;
    t_angle  r_lim_lo [NUM_AXES];
    t_angle  r_lim_hi [NUM_AXES];

    // Input stage
    logic      r_in_valid;
    logic      r_cmd;
    t_axis_sel r_axis;
    t_angle    r_target;

    // Block state outside the axes
    t_period r_ms_count;
    logic    r_fault;

    // Result stage
    logic                r_out_valid;
    t_status             r_status;
    t_angle              r_angle   [NUM_AXES];
    t_compare            r_compare [NUM_AXES];
    logic [NUM_AXES-1:0] r_moving;
    logic                r_out_fault;

    // Next-value logic
    logic                out_free;
    logic                advance;
    logic                in_load;
    logic [PERIOD_W:0]   tick_sum;
    logic                step_now;
    t_period             n_ms_count;
    logic                n_fault;
    t_status             n_status;
    logic                target_ok;
    t_angle              sel_lo;
    t_angle              sel_hi;
    t_axis_ctrl          axis_ctrl [NUM_AXES];
    t_angle              cur_next  [NUM_AXES];
    logic [NUM_AXES-1:0] moving_next;
    t_angle              rst_angle [NUM_AXES];

    // Handshake: the input register drains into the result register
    assign out_free    = !r_out_valid || i_out_ready;
    assign advance     = r_in_valid && out_free;
    assign o_in_ready  = !r_in_valid || out_free;
    assign in_load     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Hold the accepted item in the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_cmd    <= i_cmd;
            r_axis   <= i_axis;
            r_target <= i_target_angle;
        end
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_period <= RST_STEP_PERIOD;
            r_lim_lo[0]   <= RST_BASE_MIN;
            r_lim_hi[0]   <= RST_BASE_MAX;
            r_lim_lo[1]   <= RST_FRONT_MIN;
            r_lim_hi[1]   <= RST_FRONT_MAX;
            r_lim_lo[2]   <= RST_REAR_MIN;
            r_lim_hi[2]   <= RST_REAR_MAX;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_STEP_PERIOD: r_step_period <= i_cfg_data;
                REG_BASE_MIN:    r_lim_lo[0]   <= i_cfg_data[ANGLE_W-1:0];
                REG_BASE_MAX:    r_lim_hi[0]   <= i_cfg_data[ANGLE_W-1:0];
                REG_FRONT_MIN:   r_lim_lo[1]   <= i_cfg_data[ANGLE_W-1:0];
                REG_FRONT_MAX:   r_lim_hi[1]   <= i_cfg_data[ANGLE_W-1:0];
                REG_REAR_MIN:    r_lim_lo[2]   <= i_cfg_data[ANGLE_W-1:0];
                REG_REAR_MAX:    r_lim_hi[2]   <= i_cfg_data[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Count ticks; a zero period steps on every tick
    assign tick_sum = {1'b0, r_ms_count} + {{PERIOD_W{1'b0}}, 1'b1};
    assign step_now = advance && (r_cmd == CMD_TICK) &&
                      (tick_sum >= {1'b0, r_step_period});

    // Select the limits of the addressed axis
    always_comb begin
        unique case (r_axis)
            AXIS_BASE:  begin sel_lo = r_lim_lo[0]; sel_hi = r_lim_hi[0]; end
            AXIS_FRONT: begin sel_lo = r_lim_lo[1]; sel_hi = r_lim_hi[1]; end
            AXIS_REAR:  begin sel_lo = r_lim_lo[2]; sel_hi = r_lim_hi[2]; end
            default:    begin sel_lo = r_lim_lo[0]; sel_hi = r_lim_hi[0]; end
        endcase
    end

    assign target_ok = (r_target <= ANGLE_FULL) && (r_target >= sel_lo) &&
                       (r_target <= sel_hi);

    // Decode the item into status, counter, fault and axis controls
    always_comb begin
        n_ms_count = r_ms_count;
        n_fault    = r_fault;
        n_status   = STATUS_TICK;
        for (int a = 0; a < NUM_AXES; a++) begin
            axis_ctrl[a].step    = step_now;
            axis_ctrl[a].goal_we = 1'b0;
            axis_ctrl[a].goal    = r_target;
        end
        if (r_cmd == CMD_TICK) begin
            n_ms_count = step_now ? '0 : tick_sum[PERIOD_W-1:0];
        end else if (r_axis != AXIS_BASE && r_axis != AXIS_FRONT &&
                     r_axis != AXIS_REAR) begin
            n_status = STATUS_REJECT;
        end else begin
            n_status = target_ok ? STATUS_ACCEPT : STATUS_REJECT;
            for (int a = 0; a < NUM_AXES; a++) begin
                axis_ctrl[a].goal_we = advance && target_ok &&
                                       (r_axis == t_axis_sel'(a));
            end
            if (r_axis == AXIS_FRONT) begin
                n_fault = !target_ok;
            end
        end
    end

    // Commit counter and fault flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms_count <= '0;
            r_fault    <= 1'b0;
        end else if (advance) begin
            r_ms_count <= n_ms_count;
            r_fault    <= n_fault;
        end
    end

    assign rst_angle[0] = RST_BASE_ANGLE;
    assign rst_angle[1] = RST_FRONT_ANGLE;
    assign rst_angle[2] = RST_REAR_ANGLE;

    // Axis state and stepping
    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        ssl_axis u_axis (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_rst_angle   (rst_angle[g]),
            .i_advance     (advance),
            .i_ctrl        (axis_ctrl[g]),
            .o_cur_next    (cur_next[g]),
            .o_moving_next (moving_next[g])
        );
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_status    <= n_status;
            r_moving    <= moving_next;
            r_out_fault <= n_fault;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_angle[a]   <= cur_next[a];
                r_compare[a] <= angle_to_compare(cur_next[a]);
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_base_angle    = r_angle[0];
    assign o_front_angle   = r_angle[1];
    assign o_rear_angle    = r_angle[2];
    assign o_base_compare  = r_compare[0];
    assign o_front_compare = r_compare[1];
    assign o_rear_compare  = r_compare[2];
    assign o_moving_mask   = r_moving;
    assign o_front_fault   = r_out_fault;

endmodule
`default_nettype wire

### hw/rtl/ssl_axis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssl_axis
// Current and goal angle of one axis, with the one-degree step toward goal.
// ----------------------------------------------------------------------------
module ssl_axis (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ssl_pkg::t_angle     i_rst_angle,
    input  wire logic                i_advance,
    input  wire ssl_pkg::t_axis_ctrl i_ctrl,
    output ssl_pkg::t_angle          o_cur_next,
    output logic                     o_moving_next
);
    import ssl_pkg::*;

    t_angle r_cur;
    t_angle r_goal;
    t_angle n_cur;
    t_angle n_goal;

    // Step one degree toward goal when the step period elapses
    always_comb begin
        n_cur = r_cur;
        if (i_ctrl.step) begin
            if (r_cur < r_goal) begin
                n_cur = r_cur + 8'd1;
            end else if (r_cur > r_goal) begin
                n_cur = r_cur - 8'd1;
            end
        end
        n_goal = i_ctrl.goal_we ? i_ctrl.goal : r_goal;
    end

    // Commit state when the item moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= i_rst_angle;
            r_goal <= i_rst_angle;
        end else if (i_advance) begin
            r_cur  <= n_cur;
            r_goal <= n_goal;
        end
    end

    assign o_cur_next    = n_cur;
    assign o_moving_next = (n_cur != n_goal);

endmodule
`default_nettype wire
